// ===== rtl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
`default_nettype none

package bdpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned InDW   = 40;  // raw_level + now_ms, padded to bytes
  localparam int unsigned OutDW  = 8;   // event_code, padded to a byte

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_t;

  // Event codes carried in the result beat
  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_SHORT      = 2'd1,
    EV_LONG_START = 2'd2,
    EV_LONG_END   = 2'd3
  } event_t;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst = 16'd1000;

  // Timing thresholds handed from the register block to the classifier
  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/bdpc_cfg.sv =====
// Configuration registers: debounce time and long-press threshold.
`default_nettype none

module bdpc_cfg
  import bdpc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [0:0]      cfg_addr,
  input  wire logic [CfgW-1:0] cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_q;

  // Write-only register file, back to defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.long_press_ms <= LongPressRst;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_wdata;
        REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bdpc_classify.sv =====
// Debounce state and press classification, one sample per fire.
`default_nettype none

module bdpc_classify
  import bdpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic             raw_level,
  input  wire logic [TimeW-1:0] now_ms,
  input  cfg_t                  cfg,
  output event_t                event_code
);

  logic             previous_raw;
  logic             stable_level;
  logic [TimeW-1:0] change_time;
  logic [TimeW-1:0] press_start_time;
  logic             long_flagged;

  logic             stable_level_next;
  logic [TimeW-1:0] change_time_next;
  logic [TimeW-1:0] press_start_time_next;
  logic             long_flagged_next;

  logic [TimeW-1:0] since_change;
  logic [TimeW-1:0] held;
  logic [TimeW-1:0] held_after;
  logic [TimeW-1:0] debounce_w;
  logic [TimeW-1:0] long_w;
  logic             settled;
  logic             press;

  assign debounce_w = {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};
  assign long_w     = {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms};

  // Any raw edge restarts the debounce window
  assign change_time_next = (raw_level != previous_raw) ? now_ms : change_time;
  assign since_change     = now_ms - change_time_next;
  assign settled          = since_change > debounce_w;
  assign held             = now_ms - press_start_time;

  // Stable-level transitions, then the long-press check on the updated state
  always_comb begin
    stable_level_next     = stable_level;
    press_start_time_next = press_start_time;
    long_flagged_next     = long_flagged;
    event_code            = EV_NONE;
    press                 = 1'b0;
    if (settled) begin
      if (raw_level != stable_level) begin
        stable_level_next = raw_level;
        if (!raw_level) begin
          press                 = 1'b1;
          press_start_time_next = now_ms;
          long_flagged_next     = 1'b0;
        end else if (held >= long_w) begin
          long_flagged_next = 1'b0;
          event_code        = EV_LONG_END;
        end else if (!long_flagged) begin
          event_code = EV_SHORT;
        end
      end
      // a fresh press has lasted zero ms so far
      if (!stable_level_next && !long_flagged_next && (held_after >= long_w)) begin
        long_flagged_next = 1'b1;
        event_code        = EV_LONG_START;
      end
    end
  end

  assign held_after = press ? '0 : held;

  // State update once per processed sample
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw     <= 1'b1;
      stable_level     <= 1'b1;
      change_time      <= '0;
      press_start_time <= '0;
      long_flagged     <= 1'b0;
    end else if (fire) begin
      previous_raw     <= raw_level;
      stable_level     <= stable_level_next;
      change_time      <= change_time_next;
      press_start_time <= press_start_time_next;
      long_flagged     <= long_flagged_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/button_debounce_press_classifier_top.sv =====
// Top level: stream ports, input and result registers around the classifier.
// Accepted samples pass the input register and classifier into the result register.
// Throughput: one sample per cycle unless m_tready stalls; a single classify stage.
// The input side keeps taking beats while a result waits, until both registers fill.
// Reset (rst, synchronous, active high) empties both registers, restores the
// debounce state to released and the thresholds to 50 ms and 1000 ms.
`default_nettype none

module button_debounce_press_classifier_top
  import bdpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  input  wire logic [InDW-1:0]  s_tdata,   // [0] raw_level, [32:1] now_ms, rest zero
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  output      logic [OutDW-1:0] m_tdata,   // [1:0] event_code, rest zero
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_addr,
  input  wire logic [CfgW-1:0]  cfg_wdata
);

  cfg_t             cfg;
  logic             in_vld;
  logic             in_raw;
  logic [TimeW-1:0] in_now;
  logic             out_vld;
  event_t           out_ev;
  event_t           ev;
  logic             fire;

  bdpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage advances when the result register is free or draining
  assign fire     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_raw <= s_tdata[0];
      in_now <= s_tdata[TimeW:1];
    end
  end

  bdpc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .raw_level  (in_raw),
    .now_ms     (in_now),
    .cfg        (cfg),
    .event_code (ev)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ev <= ev;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{(OutDW-2){1'b0}}, out_ev};

endmodule

`default_nettype wire

// ===== rtl/bdpc_checker.sv =====
// Port-level checks for the classifier top, bound to every instance.
`default_nettype none

module bdpc_checker
  import bdpc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OutDW-1:0] m_tdata
);

  // Result beats carry only a 2-bit code
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OutDW-1:2] == '0))
    else $error("result padding bits not zero");

  // Nothing is shown right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result beat valid after reset");

  // With the result side empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // An accepted sample passes the input register, then shows as a result beat
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("accepted beat produced no result");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (.*);

`default_nettype wire
